/* sv/sha256_pkg.sv */
// sha256_pkg: shared types, constants and tables of the SHA-256 stream hasher.
// Depends on nothing; the hasher, the round unit and the bench import it.
`default_nettype none

package sha256_pkg;

    // Block geometry and padding positions
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         TOTAL_W    = 61;

    // Eight 32-bit words, index 0 is word A / H0
    typedef logic [0:7][31:0] hash_vec_t;

    localparam hash_vec_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } hash_state_t;

    // Controls from the sequencer to the round core
    typedef struct packed {
        logic       load_byte;
        logic [5:0] byte_addr;
        logic [7:0] byte_data;
        logic       init;
        logic       step;
        logic [5:0] round;
    } core_ctrl_t;

endpackage

`default_nettype wire

/* sv/sha256_if.sv */
// sha256_if: valid/ready channel interfaces for message bytes and digest words.
// Depends on nothing.
`default_nettype none

interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_valid, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last_byte,
                    output ready);
endinterface

interface sha256_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// sha256_stream_hasher: streaming SHA-256 over a byte channel, digest out as eight words.
// Depends on sha256_pkg, sha256_if (byte and word channels) and sha256_round.
//
// Usage:
//   byte_in carries one beat per message byte (data_byte with byte_valid set). A beat with
//   last_byte set ends the message; with byte_valid clear it only finishes what is held,
//   so a lone last beat gives the digest of the empty message.
//   digest_out then delivers eight beats, word_index 0..7, most significant word first,
//   last_word on the eighth. After that beat the block holds the initial hash state.
// Sequence:
//   A byte beat that does not fill the block leaves byte_in ready for the next one. The
//   64th byte starts a compression: 64 rounds on the shared round unit, then the hash
//   add. A last beat adds, for each padded block (one or two), a pass of the byte-wide
//   padding writer up to byte 63 (one byte per cycle) and a compression, then the
//   eight digest beats. byte_in.ready is low for all of that.
// Reset: rst_n is asynchronous and active low; it loads the initial hash values and
//   clears the byte counts and the sequencer.
// Stall: digest beats hold in place while digest_out.ready is low; no new input is taken
//   until the last digest beat is accepted.
`default_nettype none

module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sha256_byte_if.sink    byte_in,
    sha256_word_if.source  digest_out
);

    hash_state_t         state_reg, state_next;
    logic [5:0]          round_reg, round_next;
    logic [5:0]          fill_reg, fill_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [5:0]          pad_pos_reg, pad_pos_next;
    logic                mark_reg, mark_next;
    logic                len_ok_reg, len_ok_next;
    logic                done_reg, done_next;
    logic                fin_reg, fin_next;
    logic [2:0]          out_idx_reg, out_idx_next;
    hash_vec_t           hash_reg, hash_next;

    core_ctrl_t          ctrl;
    hash_vec_t           work;

    logic                in_fire;
    logic                out_fire;
    logic                block_full;
    logic                len_ok_eff;
    logic [63:0]         len_bits;
    logic [7:0]          pad_byte;

    assign in_fire    = byte_in.valid && byte_in.ready;
    assign out_fire   = digest_out.valid && digest_out.ready;
    assign block_full = byte_in.byte_valid && (fill_reg == LAST_POS);
    assign len_ok_eff = mark_reg ? len_ok_reg : (pad_pos_reg < LEN_POS);
    assign len_bits   = {total_reg, 3'b000};

    // Padding byte: marker first, then zeros, then the big-endian bit length
    always_comb
    begin
        if (!mark_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ok_reg && (pad_pos_reg >= LEN_POS))
        begin
            pad_byte = len_bits[{~pad_pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (block_full)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (byte_in.last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pad_pos_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (out_fire && (out_idx_reg == LAST_WORD))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        ctrl          = '0;
        ctrl.round    = round_reg;
        round_next    = round_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        pad_pos_next  = pad_pos_reg;
        mark_next     = mark_reg;
        len_ok_next   = len_ok_reg;
        done_next     = done_reg;
        fin_next      = fin_reg;
        out_idx_next  = out_idx_reg;
        hash_next     = hash_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_in.byte_valid)
                    begin
                        ctrl.load_byte = 1'b1;
                        ctrl.byte_addr = fill_reg;
                        ctrl.byte_data = byte_in.data_byte;
                        fill_next      = fill_reg + 6'd1;
                        total_next     = total_reg + {{(TOTAL_W-1){1'b0}}, 1'b1};
                    end
                    if (block_full)
                    begin
                        ctrl.init  = 1'b1;
                        round_next = '0;
                        fin_next   = byte_in.last_byte;
                    end
                    if (byte_in.last_byte)
                    begin
                        fin_next     = 1'b1;
                        pad_pos_next = fill_reg + {5'd0, byte_in.byte_valid};
                        mark_next    = 1'b0;
                        len_ok_next  = 1'b0;
                        done_next    = 1'b0;
                    end
                end
            end
            ST_ROUND:
            begin
                ctrl.step  = 1'b1;
                round_next = round_reg + 6'd1;
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + work[i];
                end
            end
            ST_PAD:
            begin
                ctrl.load_byte = 1'b1;
                ctrl.byte_addr = pad_pos_reg;
                ctrl.byte_data = pad_byte;
                pad_pos_next   = pad_pos_reg + 6'd1;
                mark_next      = 1'b1;
                len_ok_next    = len_ok_eff;
                if (pad_pos_reg == LAST_POS)
                begin
                    ctrl.init  = 1'b1;
                    round_next = '0;
                    if (len_ok_eff)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // marker landed in or past the length slot: length goes in an extra block
                        len_ok_next = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD)
                    begin
                        hash_next   = INIT_HASH;
                        fill_next   = '0;
                        total_next  = '0;
                        fin_next    = 1'b0;
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                        done_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Channel signals
    assign byte_in.ready          = (state_reg == ST_IDLE);
    assign digest_out.valid       = (state_reg == ST_OUT);
    assign digest_out.digest_word = hash_reg[out_idx_reg];
    assign digest_out.word_index  = out_idx_reg;
    assign digest_out.last_word   = (out_idx_reg == LAST_WORD);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            pad_pos_reg <= '0;
            mark_reg    <= 1'b0;
            len_ok_reg  <= 1'b0;
            done_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            out_idx_reg <= '0;
            hash_reg    <= INIT_HASH;
        end
        else
        begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            pad_pos_reg <= pad_pos_next;
            mark_reg    <= mark_next;
            len_ok_reg  <= len_ok_next;
            done_reg    <= done_next;
            fin_reg     <= fin_next;
            out_idx_reg <= out_idx_next;
            hash_reg    <= hash_next;
        end
    end

    // Shared round unit
    sha256_round u_round (
        .clk  (clk),
        .ctrl (ctrl),
        .hash (hash_reg),
        .work (work)
    );

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_in.ready && digest_out.valid))
        else $error("input taken while digest is being delivered");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_FINAL))
        else $error("compression did not end after the last round");

    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (len_ok_reg && mark_reg && fin_reg))
        else $error("length block finished without marker and length");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && digest_out.last_word) |=>
            (byte_in.ready && fill_reg == '0 && total_reg == '0))
        else $error("block not back to initial state after digest");

endmodule

`default_nettype wire

/* sv/sha256_round.sv */
// sha256_round: message window (doubles as block buffer), one SHA-256 round per cycle on ctrl.step.
// Depends on sha256_pkg.
`default_nettype none

module sha256_round
    import sha256_pkg::*;
(
    input  logic       clk,
    input  core_ctrl_t ctrl,
    input  hash_vec_t  hash,
    output hash_vec_t  work
);

    logic [31:0] sched_reg [16];
    hash_vec_t   work_reg;

    logic [31:0] w_new;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Next schedule word from the window, W[r+16]
    assign w_new = sched_reg[0] + small_sig0(sched_reg[1]) + sched_reg[9]
                 + small_sig1(sched_reg[14]);

    // Round function
    always_comb
    begin
        big_s1 = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
        ch     = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1     = work_reg[7] + big_s1 + ch + ROUND_K[ctrl.round] + sched_reg[0];
        big_s0 = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
        maj    = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        t2     = big_s0 + maj;
    end

    // Window: byte writes while filling, shift by one word per round
    always_ff @(posedge clk)
    begin
        if (ctrl.load_byte)
        begin
            sched_reg[ctrl.byte_addr[5:2]][{~ctrl.byte_addr[1:0], 3'b000} +: 8] <= ctrl.byte_data;
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_new;
        end
    end

    // Working variables a..h
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            work_reg <= hash;
        end
        else if (ctrl.step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    assign work = work_reg;

endmodule

`default_nettype wire

/* test/sha256_stream_hasher_tb.sv */
// sha256_stream_hasher_tb: self-checking bench for the streaming SHA-256 hasher.
// Depends on sha256_pkg, sha256_if and sha256_stream_hasher; byte beats in, digest words out.
`default_nettype none

module sha256_stream_hasher_tb
    import sha256_pkg::*;
;

    typedef logic [0:63][7:0] msg_block_t;

    typedef struct {
        logic [7:0] data;
        logic       bv;
        logic       last;
    } stream_beat_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic clk;
    logic rst_n;

    sha256_byte_if byte_ch ();
    sha256_word_if word_ch ();

    sha256_stream_hasher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .digest_out (word_ch)
    );

    // Stimulus and expected digest words
    stream_beat_t byte_stream [$];
    digest_beat_t pending_digest [$];
    stream_beat_t next_beat;

    // Shadow hash state
    hash_vec_t   shadow_hash;
    msg_block_t  shadow_block;
    int          shadow_fill;
    logic [60:0] shadow_total;

    int   errors;
    int   total_beats;
    int   beats_taken;
    int   messages_done;
    int   bytes_hashed;
    int   words_checked;
    int   counted_items;
    logic byte_taken;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of a block into the running hash
    function automatic hash_vec_t sha_compress(input hash_vec_t h, input msg_block_t blk);
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, g0, g1, s0, s1, ch, maj, t1, t2;
        hash_vec_t   res;
        int          j, r;
        for (j = 0; j < 16; j++)
        begin
            w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
        end
        for (j = 0; j < 8; j++)
        begin
            v[j] = h[j];
        end
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                wr = w[r];
            end
            else
            begin
                g0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                g1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                wr = w[r&15] + g0 + w[(r-7)&15] + g1;
                w[r&15] = wr;
            end
            s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + ROUND_K[r] + wr;
            s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++)
        begin
            res[j] = h[j] + v[j];
        end
        return res;
    endfunction

    task automatic clear_shadow();
        shadow_hash  = INIT_HASH;
        shadow_block = '0;
        shadow_fill  = 0;
        shadow_total = '0;
    endtask

    // Absorb one accepted beat; on last, pad and queue the eight digest words
    task automatic sha_absorb(input logic [7:0] data, input logic bv, input logic last);
        logic [63:0]  bit_len;
        int           pos, j;
        digest_beat_t d;
        if (bv)
        begin
            shadow_block[shadow_fill] = data;
            shadow_fill++;
            shadow_total = shadow_total + 61'd1;
            bytes_hashed++;
            if (shadow_fill == 64)
            begin
                shadow_hash = sha_compress(shadow_hash, shadow_block);
                shadow_fill = 0;
            end
        end
        if (last)
        begin
            bit_len = {shadow_total, 3'b000};
            pos = shadow_fill;
            shadow_block[pos] = PAD_MARK;
            pos++;
            // no room for the length: spill into an extra block
            if (pos > int'(LEN_POS))
            begin
                for (j = pos; j < 64; j++)
                begin
                    shadow_block[j] = 8'h00;
                end
                shadow_hash = sha_compress(shadow_hash, shadow_block);
                pos = 0;
            end
            for (j = pos; j < int'(LEN_POS); j++)
            begin
                shadow_block[j] = 8'h00;
            end
            for (j = 0; j < 8; j++)
            begin
                shadow_block[63-j] = bit_len[8*j +: 8];
            end
            shadow_hash = sha_compress(shadow_hash, shadow_block);
            for (j = 0; j < 8; j++)
            begin
                d.word  = shadow_hash[j];
                d.index = 3'(j);
                d.last  = (j == 7);
                pending_digest.push_back(d);
            end
            messages_done++;
            clear_shadow();
        end
    endtask

    // Stimulus builders
    task automatic push_beat(input logic [7:0] data, input logic bv, input logic last);
        stream_beat_t b;
        b.data = data;
        b.bv   = bv;
        b.last = last;
        byte_stream.push_back(b);
        counted_items++;
    endtask

    // A message of len bytes with random content and stray ignored beats;
    // ends either on its final byte or with a separate finishing beat
    task automatic push_message(input int len, input bit last_on_byte);
        int k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(7) == 0)
            begin
                push_beat(8'($urandom), 1'b0, 1'b0);
            end
            push_beat(8'($urandom), 1'b1, last_on_byte && (k == len - 1));
        end
        if (!last_on_byte || len == 0)
        begin
            push_beat(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(15);
        if (sel <= 8)
            return $urandom_range(12);
        else if (sel == 9)
            return 0;
        else if (sel <= 11)
            return 55 + $urandom_range(2);
        else if (sel <= 13)
            return 62 + $urandom_range(3);
        else if (sel == 14)
            return 119 + $urandom_range(2);
        else
            return 1 + $urandom_range(129);
    endfunction

    // Idle mix: three phases by progress through the stream
    function automatic int send_idle_pct();
        if (beats_taken < total_beats / 3)
            return 10;
        else if (beats_taken < (2 * total_beats) / 3)
            return 72;
        else
            return 0;
    endfunction

    function automatic int recv_stall_pct();
        if (beats_taken < total_beats / 3)
            return 72;
        else if (beats_taken < (2 * total_beats) / 3)
            return 10;
        else
            return 0;
    endfunction

    // Driver: new beat at the falling edge once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_ch.valid || byte_taken)
            begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct())
                begin
                    next_beat = byte_stream.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= next_beat.data;
                    byte_ch.byte_valid <= next_beat.bv;
                    byte_ch.last_byte  <= next_beat.last;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
            word_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    // Monitor: check digest beats, then feed accepted byte beats to the shadow
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (word_ch.valid && word_ch.ready)
            begin
                if (pending_digest.size() == 0)
                begin
                    report_error($sformatf("digest beat with nothing pending: word %h index %0d",
                                           word_ch.digest_word, word_ch.word_index));
                end
                else
                begin
                    automatic digest_beat_t e = pending_digest.pop_front();
                    words_checked++;
                    if (word_ch.digest_word !== e.word)
                        report_error($sformatf("digest_word %h, expected %h (index %0d)",
                                               word_ch.digest_word, e.word, e.index));
                    if (word_ch.word_index !== e.index)
                        report_error($sformatf("word_index %0d, expected %0d",
                                               word_ch.word_index, e.index));
                    if (word_ch.last_word !== e.last)
                        report_error($sformatf("last_word %b, expected %b (index %0d)",
                                               word_ch.last_word, e.last, e.index));
                end
            end
            byte_taken <= byte_ch.valid && byte_ch.ready;
            if (byte_ch.valid && byte_ch.ready)
            begin
                beats_taken++;
                sha_absorb(byte_ch.data_byte, byte_ch.byte_valid, byte_ch.last_byte);
            end
        end
    end

    // Main sequence
    initial
    begin
        errors        = 0;
        beats_taken   = 0;
        messages_done = 0;
        bytes_hashed  = 0;
        words_checked = 0;
        counted_items = 0;
        byte_taken    = 1'b0;
        rst_n         = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.byte_valid = 1'b0;
        byte_ch.last_byte  = 1'b0;
        word_ch.ready      = 1'b0;
        clear_shadow();

        // Directed: ignored beat, empty message, byte extremes, both ways to finish
        push_beat(8'hff, 1'b0, 1'b0);
        push_beat(8'h5a, 1'b0, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'hff, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'h61, 1'b1, 1'b0);
        push_beat(8'h62, 1'b1, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0);
        push_beat(8'h63, 1'b1, 1'b0);
        push_beat(8'hff, 1'b0, 1'b1);
        push_beat(8'hff, 1'b1, 1'b1);
        push_beat(8'h00, 1'b0, 1'b1);

        // Random messages, lengths weighted toward the padding boundaries
        while (counted_items < 205)
        begin
            push_message(pick_length(), 1'($urandom_range(1)));
        end
        total_beats = byte_stream.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_stream.size() != 0 || byte_ch.valid || pending_digest.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (pending_digest.size() != 0)
            report_error($sformatf("%0d digest words never arrived", pending_digest.size()));

        $display("Hashed %0d messages, %0d bytes, over %0d input beats.",
                 messages_done, bytes_hashed, beats_taken);
        $display("Checked %0d digest words; %0d errors.", words_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timed out with %0d beats left and %0d digest words pending.",
                 byte_stream.size(), pending_digest.size());
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
